FILE: rtl/swd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants of the saccade window decoder: register
// indexes, mode bits, controller commands and datapath status.
// ----------------------------------------------------------------------------
package swd_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int ZOOM_FIELD_BITS = 2;
  localparam int DEPTH_FIELD_BITS = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_BY_THREE      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ZOOM_LEVEL      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOCK_AT_MAX_ZOOM    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_ZOOMED_IN     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USE_FIXED_THRESHOLD = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_DEPTH     = 3'd7;

  localparam logic [7:0] FIXED_THRESHOLD       = 8'd160;
  localparam logic [7:0] EMPTY_DEPTH_THRESHOLD = 8'd127;
  localparam logic [7:0] THRESHOLD_TOP         = 8'd255;

  typedef struct packed {
    logic                        split3;
    logic [ZOOM_FIELD_BITS-1:0]  max_zoom;
    logic                        lock_max;
    logic                        start_in;
    logic                        use_fixed;
    logic [DEPTH_FIELD_BITS-1:0] depth;
  } swd_mode_t;

  typedef struct packed {
    logic load;      // capture a new control word
    logic prep;      // resolve the zoom level
    logic split;     // narrow one axis by one level
    logic axis;      // 0 x, 1 y
    logic thresh;    // one bisection step
    logic out_load;  // move the result into the output register
  } swd_cmd_t;

  typedef struct packed {
    logic split_done;
    logic thr_stop;
  } swd_status_t;

endpackage
`default_nettype wire

FILE: rtl/swd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module swd_cfg import swd_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_addr,
  input  wire logic [COORD_BITS-1:0]     cfg_data,
  output swd_mode_t                      mode,
  output logic [COORD_BITS-1:0]          image_width,
  output logic [COORD_BITS-1:0]          image_height
);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= {COORD_BITS{1'b1}};
      image_height   <= {COORD_BITS{1'b1}};
      mode.split3    <= 1'b1;
      mode.max_zoom  <= 2'd3;
      mode.lock_max  <= 1'b0;
      mode.start_in  <= 1'b0;
      mode.use_fixed <= 1'b1;
      mode.depth     <= 3'd0;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:         image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:        image_height   <= cfg_data;
        REG_SPLIT_BY_THREE:      mode.split3    <= cfg_data[0];
        REG_MAX_ZOOM_LEVEL:      mode.max_zoom  <= cfg_data[ZOOM_FIELD_BITS-1:0];
        REG_LOCK_AT_MAX_ZOOM:    mode.lock_max  <= cfg_data[0];
        REG_START_ZOOMED_IN:     mode.start_in  <= cfg_data[0];
        REG_USE_FIXED_THRESHOLD: mode.use_fixed <= cfg_data[0];
        REG_THRESHOLD_DEPTH:     mode.depth     <= cfg_data[DEPTH_FIELD_BITS-1:0];
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/swd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_dp
// Datapath: input capture, zoom resolution, one shared range splitter that
// narrows x and y in turn, the threshold bisection and the output register.
// ----------------------------------------------------------------------------
module swd_dp import swd_pkg::*; #(
  parameter  int MAX_ZOOM            = 3,
  parameter  int MAX_THRESHOLD_DEPTH = 4,
  parameter  int PHASE_BITS          = 4,
  parameter  int COORD_BITS          = 10,
  localparam int LW = $clog2(MAX_ZOOM + 1),
  localparam int TW = $clog2(MAX_THRESHOLD_DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire swd_cmd_t                         cmd,
  input  wire logic [LW-1:0]                    lvl,
  input  wire logic [TW-1:0]                    tk,
  input  wire swd_mode_t                        mode,
  input  wire logic [COORD_BITS-1:0]            image_width,
  input  wire logic [COORD_BITS-1:0]            image_height,
  input  wire logic [PHASE_BITS-1:0]            phase_bits,
  input  wire logic [MAX_ZOOM-1:0]              zoom_bits,
  input  wire logic [2*MAX_ZOOM-1:0]            x_position_bits,
  input  wire logic [2*MAX_ZOOM-1:0]            y_position_bits,
  input  wire logic [2*MAX_THRESHOLD_DEPTH-1:0] threshold_bits,
  output swd_status_t                           status,
  output logic [PHASE_BITS-1:0]                 phase,
  output logic [LW-1:0]                         zoom_level,
  output logic [COORD_BITS-1:0]                 x_start,
  output logic [COORD_BITS-1:0]                 x_end,
  output logic [COORD_BITS-1:0]                 y_start,
  output logic [COORD_BITS-1:0]                 y_end,
  output logic [7:0]                            threshold
);

  // floor(r/3) as (r * RECIP) >> RK, exact for every r below 2**COORD_BITS
  localparam int RK    = COORD_BITS + 2;
  localparam int RECIP = ((1 << RK) + 2) / 3;
  localparam int PW    = COORD_BITS + RK;

  logic [PHASE_BITS-1:0]            ph_r;
  logic [MAX_ZOOM-1:0]              zb_r;
  logic [2*MAX_ZOOM-1:0]            xb_r;
  logic [2*MAX_ZOOM-1:0]            yb_r;
  logic [2*MAX_THRESHOLD_DEPTH-1:0] tb_r;
  logic [LW-1:0]                    zoom_r;
  logic [COORD_BITS-1:0]            xs, xe, ys, ye;
  logic [7:0]                       lo, hi, thr;
  logic                             thr_stop;

  // Zoom level
  logic [LW-1:0] maxz, ones, zoom_next;
  logic          run;

  always_comb begin
    if (int'(mode.max_zoom) > MAX_ZOOM) maxz = LW'(MAX_ZOOM);
    else                                maxz = LW'(mode.max_zoom);
    ones = '0;
    run  = 1'b1;
    for (int i = 0; i < MAX_ZOOM; i++) begin
      if (run && (i < int'(maxz)) && zb_r[i]) ones = ones + LW'(1);
      else                                    run  = 1'b0;
    end
    priority if (mode.lock_max) zoom_next = maxz;
    else if (mode.start_in)     zoom_next = maxz - ones;
    else                        zoom_next = ones;
  end

  // Shared splitter
  logic [COORD_BITS-1:0] cur_s, cur_e, r, q1, q2, half, new_s, new_e;
  logic [2*MAX_ZOOM-1:0] ctl;
  logic [PW-1:0]         prod;
  logic [COORD_BITS+1:0] three_q1;
  logic [1:0]            rem;
  logic                  pick_outer, pick_upper, pick_bin;

  always_comb begin
    cur_s = cmd.axis ? ys : xs;
    cur_e = cmd.axis ? ye : xe;
    ctl   = cmd.axis ? yb_r : xb_r;
    r     = cur_e - cur_s;

    pick_outer = 1'b0;
    pick_upper = 1'b0;
    pick_bin   = 1'b0;
    for (int i = 0; i < MAX_ZOOM; i++) begin
      if (lvl == LW'(i)) begin
        pick_outer = ctl[2*i];
        pick_upper = ctl[2*i+1];
        pick_bin   = ctl[i];
      end
    end

    prod     = PW'(r) * PW'(RECIP);
    q1       = prod[PW-1:RK];
    three_q1 = (COORD_BITS+2)'(q1) * (COORD_BITS+2)'(3);
    rem      = 2'((COORD_BITS+2)'(r) - three_q1);
    q2       = COORD_BITS'({q1, 1'b0}) + COORD_BITS'(rem == 2'd2);
    half     = r >> 1;

    if (mode.split3) begin
      priority if (pick_outer && pick_upper) begin
        new_s = cur_s + q2;
        new_e = cur_e;
      end else if (pick_outer) begin
        new_s = cur_s;
        new_e = cur_s + q1;
      end else begin
        new_s = cur_s + q1;
        new_e = cur_s + q2;
      end
    end else if (pick_bin) begin
      new_s = cur_s + half;
      new_e = cur_e;
    end else begin
      new_s = cur_s;
      new_e = cur_s + half;
    end
  end

  // Bisection step
  logic [7:0] mid;
  logic       t_cont, t_up;

  always_comb begin
    mid    = lo + ((hi - lo) >> 1);
    t_cont = 1'b0;
    t_up   = 1'b0;
    for (int i = 0; i < MAX_THRESHOLD_DEPTH; i++) begin
      if (tk == TW'(i)) begin
        t_cont = tb_r[2*i];
        t_up   = tb_r[2*i+1];
      end
    end
  end

  assign status.split_done = (lvl == zoom_r);
  assign status.thr_stop   = thr_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_stop <= 1'b0;
    end else if (cmd.load) begin
      thr_stop <= 1'b0;
    end else if (cmd.thresh && !t_cont) begin
      thr_stop <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ph_r <= phase_bits;
      zb_r <= zoom_bits;
      xb_r <= x_position_bits;
      yb_r <= y_position_bits;
      tb_r <= threshold_bits;
      xs   <= '0;
      xe   <= image_width;
      ys   <= '0;
      ye   <= image_height;
      lo   <= '0;
      hi   <= THRESHOLD_TOP;
      thr  <= EMPTY_DEPTH_THRESHOLD;
    end
    if (cmd.prep) zoom_r <= zoom_next;
    if (cmd.split) begin
      if (cmd.axis) begin
        ys <= new_s;
        ye <= new_e;
      end else begin
        xs <= new_s;
        xe <= new_e;
      end
    end
    if (cmd.thresh) begin
      thr <= mid;
      if (t_cont) begin
        if (t_up) lo <= mid;
        else      hi <= mid + 8'd1;
      end
    end
    if (cmd.out_load) begin
      phase      <= ph_r;
      zoom_level <= zoom_r;
      x_start    <= xs;
      x_end      <= xe;
      y_start    <= ys;
      y_end      <= ye;
      threshold  <= mode.use_fixed ? FIXED_THRESHOLD : thr;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/swd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_ctrl
// Controller: sequences capture, zoom resolution, the split levels (x then
// y per level), the bisection steps and the load of the output register.
// ----------------------------------------------------------------------------
module swd_ctrl import swd_pkg::*; #(
  parameter  int MAX_ZOOM            = 3,
  parameter  int MAX_THRESHOLD_DEPTH = 4,
  localparam int LW = $clog2(MAX_ZOOM + 1),
  localparam int TW = $clog2(MAX_THRESHOLD_DEPTH + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire swd_mode_t   mode,
  input  wire swd_status_t status,
  output swd_cmd_t         cmd,
  output logic [LW-1:0]    lvl,
  output logic [TW-1:0]    tk
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SPLIT  = 3'd2;
  localparam logic [2:0] S_THRESH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]    state;
  logic          axis;
  logic [TW-1:0] depth_eff;
  logic          thr_done;

  always_comb begin
    if (mode.use_fixed)                                depth_eff = '0;
    else if (int'(mode.depth) > MAX_THRESHOLD_DEPTH)   depth_eff = TW'(MAX_THRESHOLD_DEPTH);
    else                                               depth_eff = TW'(mode.depth);
  end

  assign thr_done     = (tk == depth_eff) || status.thr_stop;
  assign in_ready     = (state == S_IDLE);
  assign cmd.load     = in_valid && in_ready;
  assign cmd.prep     = (state == S_PREP);
  assign cmd.split    = (state == S_SPLIT) && !status.split_done;
  assign cmd.axis     = axis;
  assign cmd.thresh   = (state == S_THRESH) && !thr_done;
  assign cmd.out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
      lvl   <= '0;
      tk    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_PREP;
            axis  <= 1'b0;
            lvl   <= '0;
            tk    <= '0;
          end
        end
        S_PREP: state <= S_SPLIT;
        S_SPLIT: begin
          if (status.split_done) begin
            state <= S_THRESH;
          end else begin
            // advance the level once both axes are narrowed
            axis <= ~axis;
            if (axis) lvl <= lvl + LW'(1);
          end
        end
        S_THRESH: begin
          if (thr_done) state <= S_FINISH;
          else          tk    <= tk + TW'(1);
        end
        S_FINISH: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_load_to_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_PREP)
    else $error("capture did not start zoom resolution");

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    int'(lvl) <= MAX_ZOOM)
    else $error("split level beyond maximum zoom");

  a_tk_range: assert property (@(posedge clk) disable iff (rst)
    state == S_THRESH |-> tk <= depth_eff)
    else $error("bisection step beyond depth");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without transfer");
`endif

endmodule
`default_nettype wire

FILE: rtl/saccade_window_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saccade_window_decoder
// Decodes one control word into a phase, a zoom level, an x/y view window
// and a binarization threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one control word per transfer;
//   output channel out_valid/out_ready carries one result per control word.
//   Configuration is written through cfg_write/cfg_addr/cfg_data while idle.
//   One word is decoded at a time: from its transfer to the load of the output
//   register, a word goes through zoom resolution, Z split levels (Z the zoom
//   level) and T bisection steps (T at most the threshold depth, none with
//   the fixed threshold). The x and y ranges share one splitter, so each zoom
//   level narrows x and then y; the bisection steps follow the split levels.
//   The next word is taken as soon as the result is in the output register,
//   even while that result waits. A stalled receiver holds the result; the
//   decoder then waits with the following word's result until it is taken.
//   Synchronous reset clears the controller, empties the output register
//   and restores the configuration defaults.
// ----------------------------------------------------------------------------
module saccade_window_decoder import swd_pkg::*; #(
  parameter  int MAX_ZOOM            = 3,
  parameter  int MAX_THRESHOLD_DEPTH = 4,
  parameter  int PHASE_BITS          = 4,
  parameter  int COORD_BITS          = 10,
  localparam int LW = $clog2(MAX_ZOOM + 1),
  localparam int TW = $clog2(MAX_THRESHOLD_DEPTH + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0]        cfg_addr,
  input  wire logic [COORD_BITS-1:0]            cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [PHASE_BITS-1:0]            phase_bits,
  input  wire logic [MAX_ZOOM-1:0]              zoom_bits,
  input  wire logic [2*MAX_ZOOM-1:0]            x_position_bits,
  input  wire logic [2*MAX_ZOOM-1:0]            y_position_bits,
  input  wire logic [2*MAX_THRESHOLD_DEPTH-1:0] threshold_bits,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [PHASE_BITS-1:0]                 phase,
  output logic [LW-1:0]                         zoom_level,
  output logic [COORD_BITS-1:0]                 x_start,
  output logic [COORD_BITS-1:0]                 x_end,
  output logic [COORD_BITS-1:0]                 y_start,
  output logic [COORD_BITS-1:0]                 y_end,
  output logic [7:0]                            threshold
);

  swd_mode_t             mode;
  swd_cmd_t              cmd;
  swd_status_t           status;
  logic [COORD_BITS-1:0] image_width;
  logic [COORD_BITS-1:0] image_height;
  logic [LW-1:0]         lvl;
  logic [TW-1:0]         tk;

  swd_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .image_width  (image_width),
    .image_height (image_height)
  );

  swd_ctrl #(
    .MAX_ZOOM            (MAX_ZOOM),
    .MAX_THRESHOLD_DEPTH (MAX_THRESHOLD_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mode      (mode),
    .status    (status),
    .cmd       (cmd),
    .lvl       (lvl),
    .tk        (tk)
  );

  swd_dp #(
    .MAX_ZOOM            (MAX_ZOOM),
    .MAX_THRESHOLD_DEPTH (MAX_THRESHOLD_DEPTH),
    .PHASE_BITS          (PHASE_BITS),
    .COORD_BITS          (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .lvl             (lvl),
    .tk              (tk),
    .mode            (mode),
    .image_width     (image_width),
    .image_height    (image_height),
    .phase_bits      (phase_bits),
    .zoom_bits       (zoom_bits),
    .x_position_bits (x_position_bits),
    .y_position_bits (y_position_bits),
    .threshold_bits  (threshold_bits),
    .status          (status),
    .phase           (phase),
    .zoom_level      (zoom_level),
    .x_start         (x_start),
    .x_end           (x_end),
    .y_start         (y_start),
    .y_end           (y_end),
    .threshold       (threshold)
  );

endmodule
`default_nettype wire

FILE: dv/saccade_window_decoder_tb.sv
// ----------------------------------------------------------------------------
// saccade_window_decoder_tb
// Self-checking bench for the window decoder. Control words go in over a
// valid/ready channel. A scoreboard computes the expected phase, zoom level,
// x/y window and threshold from its own copy of the configuration, and
// checks every result transfer against the oldest expectation. The run has
// a short directed part, then randomized phases with different settings.
// Both sides idle in random bursts, and the receiver has one long hold-off.
// ----------------------------------------------------------------------------
module saccade_window_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swd_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int LIMIT_NS        = 4_000_000;
  localparam int HOLD_CYCLES     = 200;
  localparam int HOLD_ITEMS      = 24;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASE_COUNT     = 14;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int QUIET_PHASES    = 3;
  localparam int ZOOM_LIMIT      = 3;
  localparam int DEPTH_LIMIT     = 4;

  typedef struct {
    logic [3:0] phase;
    logic [2:0] zoom;
    logic [5:0] xpos;
    logic [5:0] ypos;
    logic [7:0] thr;
  } ctrl_word_t;

  typedef struct {
    logic [3:0] phase;
    logic [1:0] zoom;
    logic [9:0] xs;
    logic [9:0] xe;
    logic [9:0] ys;
    logic [9:0] ye;
    logic [7:0] thr;
  } view_t;

  class window_scoreboard;
    view_t      expected_q[$];
    int         n_errors;
    logic [9:0] width;
    logic [9:0] height;
    logic       split3;
    logic [1:0] max_zoom;
    logic       lock_max;
    logic       start_in;
    logic       use_fixed;
    logic [2:0] depth;

    function new();
      n_errors  = 0;
      width     = 10'd1023;
      height    = 10'd1023;
      split3    = 1'b1;
      max_zoom  = 2'd3;
      lock_max  = 1'b0;
      start_in  = 1'b0;
      use_fixed = 1'b1;
      depth     = 3'd0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [9:0] d);
      case (idx)
        REG_IMAGE_WIDTH:         width     = d;
        REG_IMAGE_HEIGHT:        height    = d;
        REG_SPLIT_BY_THREE:      split3    = d[0];
        REG_MAX_ZOOM_LEVEL:      max_zoom  = d[1:0];
        REG_LOCK_AT_MAX_ZOOM:    lock_max  = d[0];
        REG_START_ZOOMED_IN:     start_in  = d[0];
        REG_USE_FIXED_THRESHOLD: use_fixed = d[0];
        REG_THRESHOLD_DEPTH:     depth     = d[2:0];
        default: ;
      endcase
    endfunction

    // Narrow [0, upper) one level at a time; divisions truncate.
    function void narrow(int upper, int levels, logic [5:0] ctl,
                         output int lo, output int hi);
      int r;
      int c;
      int n;
      lo = 0;
      hi = upper;
      for (int l = 0; l < levels; l++) begin
        r = hi - lo;
        if (split3) begin
          n = 3;
          if (ctl[2*l]) c = ctl[2*l+1] ? 2 : 0;
          else c = 1;
        end else begin
          n = 2;
          c = ctl[l];
        end
        hi = lo + (r * (c + 1)) / n;
        lo = lo + (r * c) / n;
      end
    endfunction

    function logic [7:0] bisect(logic [7:0] ctl);
      int lo;
      int hi;
      int mid;
      int steps;
      if (use_fixed) return FIXED_THRESHOLD;
      steps = (depth > DEPTH_LIMIT) ? DEPTH_LIMIT : depth;
      lo = 0;
      hi = THRESHOLD_TOP;
      mid = EMPTY_DEPTH_THRESHOLD;
      for (int k = 0; k < steps; k++) begin
        mid = lo + (hi - lo) / 2;
        if (!ctl[2*k]) return 8'(mid);
        if (ctl[2*k+1]) lo = mid;
        else hi = mid + 1;
      end
      return 8'(mid);
    endfunction

    function void note_word(ctrl_word_t w);
      view_t v;
      int    top;
      int    ones;
      int    lvl;
      int    lo;
      int    hi;
      top = (max_zoom > ZOOM_LIMIT) ? ZOOM_LIMIT : max_zoom;
      ones = 0;
      while (ones < top && w.zoom[ones]) ones++;
      if (lock_max) lvl = top;
      else if (start_in) lvl = top - ones;
      else lvl = ones;
      v.phase = w.phase;
      v.zoom  = 2'(lvl);
      narrow(width, lvl, w.xpos, lo, hi);
      v.xs = 10'(lo);
      v.xe = 10'(hi);
      narrow(height, lvl, w.ypos, lo, hi);
      v.ys = 10'(lo);
      v.ye = 10'(hi);
      v.thr = bisect(w.thr);
      expected_q.insert(expected_q.size(), v);
    endfunction

    function void compare(string name, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(view_t got);
      view_t want;
      if (expected_q.size() == 0) begin
        $error("result with no expectation waiting: phase %0d", got.phase);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("phase", want.phase, got.phase);
      compare("zoom_level", want.zoom, got.zoom);
      compare("x_start", want.xs, got.xs);
      compare("x_end", want.xe, got.xe);
      compare("y_start", want.ys, got.ys);
      compare("y_end", want.ye, got.ye);
      compare("threshold", want.thr, got.thr);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_addr;
  logic [9:0]                cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [3:0]                phase_bits;
  logic [2:0]                zoom_bits;
  logic [5:0]                x_position_bits;
  logic [5:0]                y_position_bits;
  logic [7:0]                threshold_bits;
  logic                      out_valid;
  logic                      out_ready;
  logic [3:0]                phase;
  logic [1:0]                zoom_level;
  logic [9:0]                x_start;
  logic [9:0]                x_end;
  logic [9:0]                y_start;
  logic [9:0]                y_end;
  logic [7:0]                threshold;

  window_scoreboard sb;
  view_t            seen_view;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               rx_hold_req;
  int               rx_hold_left;
  int               rx_stall_left;

  saccade_window_decoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .phase_bits      (phase_bits),
    .zoom_bits       (zoom_bits),
    .x_position_bits (x_position_bits),
    .y_position_bits (y_position_bits),
    .threshold_bits  (threshold_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase           (phase),
    .zoom_level      (zoom_level),
    .x_start         (x_start),
    .x_end           (x_end),
    .y_start         (y_start),
    .y_end           (y_end),
    .threshold       (threshold)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #LIMIT_NS;
    $display("status: fail");
    $finish;
  end

  // Result side: random stall bursts, plus the long hold-off on request.
  initial begin
    out_ready = 1'b0;
    rx_hold_left = 0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (rst) begin
        out_ready = 1'b0;
      end else if (rx_hold_left > 0) begin
        out_ready = 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready = 1'b0;
        rx_stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        rx_stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_view.phase = phase;
      seen_view.zoom  = zoom_level;
      seen_view.xs    = x_start;
      seen_view.xe    = x_end;
      seen_view.ys    = y_start;
      seen_view.ye    = y_end;
      seen_view.thr   = threshold;
      sb.check_result(seen_view);
    end
  end

  task automatic drive_word(input ctrl_word_t w);
    @(negedge clk);
    in_valid        = 1'b1;
    phase_bits      = w.phase;
    zoom_bits       = w.zoom;
    x_position_bits = w.xpos;
    y_position_bits = w.ypos;
    threshold_bits  = w.thr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic send(input logic [3:0] p, input logic [2:0] z, input logic [5:0] x,
                      input logic [5:0] y, input logic [7:0] t);
    ctrl_word_t w;
    w.phase = p;
    w.zoom  = z;
    w.xpos  = x;
    w.ypos  = y;
    w.thr   = t;
    drive_word(w);
  endtask

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Hold the input until every expected result has come back.
  task automatic wait_all_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [9:0] d);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_write = 1'b1;
    cfg_addr  = idx;
    cfg_data  = d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Write all registers once the block is empty; noisy puts random junk
  // above the narrow fields.
  task automatic apply_config(input logic [9:0] w, input logic [9:0] h, input bit s3,
                              input logic [1:0] mz, input bit lk, input bit si,
                              input bit fx, input logic [2:0] dp, input bit noisy);
    logic [9:0] junk;
    wait_all_done();
    junk = noisy ? 10'($urandom) : 10'd0;
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_SPLIT_BY_THREE, (junk & ~10'h1) | 10'(s3));
    set_reg(REG_MAX_ZOOM_LEVEL, (junk & ~10'h3) | 10'(mz));
    set_reg(REG_LOCK_AT_MAX_ZOOM, (junk & ~10'h1) | 10'(lk));
    set_reg(REG_START_ZOOMED_IN, (junk & ~10'h1) | 10'(si));
    set_reg(REG_USE_FIXED_THRESHOLD, (junk & ~10'h1) | 10'(fx));
    set_reg(REG_THRESHOLD_DEPTH, (junk & ~10'h7) | 10'(dp));
  endtask

  function automatic logic [9:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 10'd1023;
      1: return 10'd1;
      2: return 10'd0;
      3: return 10'($urandom_range(2, 9));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic ctrl_word_t rand_word();
    ctrl_word_t w;
    w.phase = 4'($urandom);
    w.zoom  = 3'($urandom);
    w.xpos  = 6'($urandom);
    w.ypos  = 6'($urandom);
    w.thr   = 8'($urandom);
    // Set every continue bit half the time so deep searches are reached.
    if ($urandom_range(0, 1) == 1) w.thr = w.thr | 8'h55;
    return w;
  endfunction

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_addr        = REG_IMAGE_WIDTH;
    cfg_data        = 10'd0;
    in_valid        = 1'b0;
    phase_bits      = 4'd0;
    zoom_bits       = 3'd0;
    x_position_bits = 6'd0;
    y_position_bits = 6'd0;
    threshold_bits  = 8'd0;
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    rx_hold_req     = 1'b0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes at the reset settings
    send(4'h0, 3'b000, 6'h00, 6'h00, 8'h00);
    send(4'hF, 3'b111, 6'h3F, 6'h3F, 8'hFF);
    send(4'h5, 3'b011, 6'h2A, 6'h15, 8'h0F);
    send(4'hA, 3'b101, 6'h3C, 6'h03, 8'hF0);
    // Binary split, search depth zero with fixed threshold off
    apply_config(10'd1023, 10'd1023, 1'b0, 2'd3, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0);
    send(4'h3, 3'b111, 6'h3F, 6'h00, 8'hFF);
    send(4'hC, 3'b110, 6'h2A, 6'h15, 8'h00);
    // Depth beyond the limit; search running out, going low, stopping at once
    apply_config(10'd1000, 10'd999, 1'b1, 2'd3, 1'b0, 1'b0, 1'b0, 3'd7, 1'b0);
    send(4'h1, 3'b111, 6'h3F, 6'h03, 8'hFF);
    send(4'h2, 3'b111, 6'h05, 6'h0F, 8'h55);
    send(4'h4, 3'b001, 6'h01, 6'h00, 8'hAA);
    // Empty image, zoom locked at max
    apply_config(10'd0, 10'd0, 1'b1, 2'd3, 1'b1, 1'b0, 1'b0, 3'd4, 1'b0);
    send(4'h8, 3'b000, 6'h3F, 6'h3F, 8'h7F);
    send(4'h7, 3'b111, 6'h00, 6'h00, 8'hD5);
    // Reversed zoom count with a smaller max
    apply_config(10'd1, 10'd1022, 1'b0, 2'd2, 1'b0, 1'b1, 1'b0, 3'd3, 1'b0);
    send(4'h6, 3'b000, 6'h3F, 6'h3F, 8'h15);
    send(4'h9, 3'b001, 6'h15, 6'h2A, 8'h35);
    send(4'hB, 3'b011, 6'h3F, 6'h00, 8'h3F);
    send(4'hD, 3'b111, 6'h00, 6'h3F, 8'h01);
    // Zoom disabled
    apply_config(10'd1023, 10'd1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b1, 3'd2, 1'b0);
    send(4'hF, 3'b111, 6'h3F, 6'h3F, 8'h00);
    send(4'h0, 3'b000, 6'h00, 6'h00, 8'hFF);
    wait_all_done();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 0) begin
        apply_config(10'd1023, 10'd1023, 1'b1, 2'd3, 1'b1, 1'b1, 1'b1, 3'd7, 1'b1);
      end else if (ph == 1) begin
        apply_config(10'd0, 10'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0, 1'b1);
      end else begin
        apply_config(pick_size(), pick_size(), 1'($urandom),
                     ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'd3,
                     ($urandom_range(0, 3) == 0), 1'($urandom),
                     ($urandom_range(0, 3) == 0), 3'($urandom), 1'b1);
      end
      if (ph < PHASE_COUNT - QUIET_PHASES) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end else begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      // Back up the block: receiver holds off while words keep coming
      if (ph == 3) begin
        rx_hold_req = 1'b1;
        repeat (HOLD_ITEMS) drive_word(rand_word());
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 6 && i == ITEMS_PER_PHASE / 2) wait_all_done();
        if (tx_idle_on && $urandom_range(0, 9) == 0) idle_input($urandom_range(1, 18));
        drive_word(rand_word());
      end
      wait_all_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
